// ----- sv/ple_pkg.sv -----
// Shared types and constants for the positional list engine.
// No dependencies; compiled first.
`default_nettype none

package ple_pkg;

  localparam int DATA_W        = 32;
  localparam int ACT_W         = 2;
  localparam int POS_W         = 5;
  localparam int ST_W          = 2;
  localparam int LEN_W         = 5;
  localparam int MAX_DEPTH     = 64;
  localparam int DEFAULT_DEPTH = 16;
  localparam int IDX_W         = $clog2(MAX_DEPTH);

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NONE   = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [IDX_W-1:0]  tgt;
    logic [DATA_W-1:0] wdata;
  } ple_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/ple_if.sv -----
// Valid/ready channel interfaces for the positional list engine.
// Depends on ple_pkg.
`default_nettype none

interface ple_in_if import ple_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, action, position, value, input ready);
  modport sink   (input valid, action, position, value, output ready);
endinterface

interface ple_out_if import ple_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ST_W-1:0]          status;
  logic [LEN_W-1:0]         length;
  logic signed [DATA_W-1:0] value_out;

  modport source (output valid, status, length, value_out, input ready);
  modport sink   (input valid, status, length, value_out, output ready);
endinterface

`default_nettype wire

// ----- sv/ple_cell.sv -----
// One storage cell of the list chain: holds one entry, shifts with its neighbors.
// Depends on ple_pkg.
`default_nettype none

module ple_cell import ple_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire logic              clk,
  input  wire ple_ctrl_t         ctrl,
  input  wire logic [DATA_W-1:0] left_q,
  input  wire logic [DATA_W-1:0] right_q,
  output logic      [DATA_W-1:0] entry_q,
  output logic      [DATA_W-1:0] sel_q
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [DATA_W-1:0] entry_r;
  logic [DATA_W-1:0] entry_nxt;
  logic              hit;

  assign hit = (ctrl.tgt == MY_IDX);

  always_comb begin
    entry_nxt = entry_r;
    case (ctrl.op)
      CELL_INS: begin
        if (MY_IDX > ctrl.tgt) begin
          entry_nxt = left_q;
        end else if (hit) begin
          entry_nxt = ctrl.wdata;
        end
      end
      CELL_DEL: begin
        if (MY_IDX >= ctrl.tgt) begin
          entry_nxt = right_q;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_q = entry_r;
  assign sel_q   = hit ? entry_r : '0;

endmodule

`default_nettype wire

// ----- sv/positional_list_engine_unit.sv -----
// Top level of the positional list engine: control, entry count, cell chain, result register.
// Depends on ple_pkg, ple_in_if, ple_out_if and ple_cell.
//
//   channel   dir  signals
//   in_chan   in   valid, ready, action, position, value
//   out_chan  out  valid, ready, status, length, value_out
//
// One transaction per cycle unless the result stalls: in the accepting cycle of an insert or
// delete the cells at or above the target shift or load; the result lands in the output
// register at the same edge. A new transaction is taken while the held result is being taken.
// A stalled result blocks input only while the output register is full.
// Reset (synchronous, active low) empties the list; entry contents are not cleared.
`default_nettype none

module positional_list_engine_unit import ple_pkg::*; #(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ple_in_if.sink    in_chan,
  ple_out_if.source out_chan
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     out_valid_r;
  logic [ST_W-1:0]          status_r, status_nxt;
  logic [LEN_W-1:0]         length_r;
  logic signed [DATA_W-1:0] value_r;
  logic [DATA_W-1:0]        res_nxt;
  logic                     fire;
  logic                     take_sel;
  logic [CMP_W-1:0]         pos_c, cnt_c, last_c, tgt_c;
  ple_ctrl_t                ctrl;
  logic [DATA_W-1:0]        entry_q [DEPTH];
  logic [DATA_W-1:0]        sel_q   [DEPTH];
  logic [DATA_W-1:0]        sel_or;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign fire          = in_chan.valid && in_chan.ready;

  assign pos_c  = CMP_W'(in_chan.position);
  assign cnt_c  = CMP_W'(cnt_r);
  assign last_c = cnt_c - CMP_W'(1);

  always_comb begin
    cell_op_t op;
    op         = CELL_HOLD;
    tgt_c      = pos_c;
    cnt_nxt    = cnt_r;
    status_nxt = ST_OK;
    take_sel   = 1'b0;
    unique case (in_chan.action)
      ACT_INSERT: begin
        if (cnt_r == CNT_FULL) begin
          status_nxt = ST_FULL;
        end else begin
          op      = CELL_INS;
          tgt_c   = (pos_c >= cnt_c) ? cnt_c : pos_c;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ACT_DELETE: begin
        if (cnt_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          op       = CELL_DEL;
          tgt_c    = (pos_c >= last_c) ? last_c : pos_c;
          cnt_nxt  = cnt_r - CNT_W'(1);
          take_sel = 1'b1;
        end
      end
      ACT_READ: begin
        if (pos_c < cnt_c) begin
          take_sel = 1'b1;
        end else begin
          status_nxt = ST_RANGE;
        end
      end
      default: begin
        op = CELL_HOLD;
      end
    endcase
    ctrl.op    = fire ? op : CELL_HOLD;
    ctrl.tgt   = IDX_W'(tgt_c);
    ctrl.wdata = in_chan.value;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_q, right_q;
    if (i == 0) begin : g_first
      assign left_q = '0;
    end else begin : g_mid_l
      assign left_q = entry_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_mid_r
      assign right_q = entry_q[i+1];
    end
    ple_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .left_q  (left_q),
      .right_q (right_q),
      .entry_q (entry_q[i]),
      .sel_q   (sel_q[i])
    );
  end

  always_comb begin
    sel_or = '0;
    for (int k = 0; k < DEPTH; k++) begin
      sel_or = sel_or | sel_q[k];
    end
    res_nxt = take_sel ? sel_or : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (fire) begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r <= status_nxt;
      length_r <= LEN_W'(cnt_nxt);
      value_r  <= res_nxt;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.status    = status_r;
  assign out_chan.length    = length_r;
  assign out_chan.value_out = value_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("entry count above depth");

  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_chan.action == ACT_INSERT && cnt_r != CNT_FULL
    |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_del_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_chan.action == ACT_DELETE && cnt_r != '0
    |=> cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("delete did not shrink the list");

  a_rd_keep: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (in_chan.action == ACT_READ || in_chan.action == ACT_NONE)
    |=> $stable(cnt_r))
    else $error("read changed the list length");

  a_res_load: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("accepted transaction produced no result");

endmodule

`default_nettype wire
